// File: src/pwps_pkg.sv
// Package for the periodic wavetable packet source: sizes, opcodes, register
// indexes, controller states and the structs passed between the modules.
// No dependencies.
package pwps_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int MAX_SAMPLES = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SLOT_W      = 5;
    localparam int TOTAL_W     = 6;
    localparam int SAMPLE_W    = 16;
    localparam int TIME_W      = 32;
    localparam int BIT_W       = $clog2(ADDR_W);

    localparam logic [15:0]      RST_PERIOD  = 16'd1;
    localparam logic [9:0]       RST_TLEN    = 10'd360;
    localparam logic [5:0]       RST_NSAMP   = 6'(MAX_SAMPLES);

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RESTART = 2'd1,
        OP_WRITE   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_PERIOD = 2'd0,
        CFG_TLEN   = 2'd1,
        CFG_NSAMP  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_ISSUE
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]  seq;
        logic [TIME_W-1:0]  ptime;
        logic [ADDR_W-1:0]  start;
        logic [TOTAL_W-1:0] total;
        logic [SLOT_W-1:0]  slot;
        logic               last;
        logic               zero;
    } res_info_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   waddr;
        logic [SAMPLE_W-1:0] wdata;
        logic                re;
        logic [ADDR_W-1:0]   raddr;
    } ram_req_t;

endpackage

// File: src/periodic_wavetable_packet_source.sv
// Top level of the periodic wavetable packet source: controller, read-index
// remainder step, two-stage result pipeline and configuration registers.
// Depends on pwps_pkg and pwps_table_ram.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  opcode, now, table write
//  m_axis    out        m_axis_tvalid / m_axis_tready  one packet sample each
//  cfg       in         cfg_we (no wait)               period, length, samples
//
// Table writes, restarts and ticks that are not due are taken in IDLE. A due
// tick then issues one table read per cycle while the result pipeline has
// room and holds the input until the packet is issued (a header-only packet
// gives one result and no read); a remainder pass over the read index bits
// comes first when the read index is not below the table length. The table
// has no reset and no clearing pass; the scheduling, valid and config registers
// clear on a low aresetn at a rising edge. A stall on m_axis backs up the
// two-stage result pipeline and then holds the read sequence.
module periodic_wavetable_packet_source (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // now_ms, table_addr, table_value
    input  logic [1:0]   s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,  // packet_seq, packet_time, start_index,
                                        // sample_total, sample_slot, sample
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wdata
);

    localparam int AW = pwps_pkg::ADDR_W;
    localparam int LW = pwps_pkg::LEN_W;
    localparam int CW = pwps_pkg::CNT_W;
    localparam int TW = pwps_pkg::TIME_W;
    localparam int SW = pwps_pkg::SAMPLE_W;
    localparam int BW = pwps_pkg::BIT_W;

    pwps_pkg::state_t    state_reg, state_next;
    logic [15:0]         period_reg;
    logic [9:0]          tlen_reg;
    logic [5:0]          nsamp_reg;
    logic [AW-1:0]       rdidx_reg, rdidx_next;
    logic [TW-1:0]       seq_reg, seq_next;
    logic [TW-1:0]       deadline_reg, deadline_next;
    logic [TW-1:0]       time_reg, time_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [AW-1:0]       start_reg, start_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [LW-1:0]       rem_reg, rem_next;
    logic [BW-1:0]       bit_reg, bit_next;

    logic                s1_vld_reg, s1_vld_next;
    pwps_pkg::res_info_t s1_info_reg, s1_info_next;
    logic                m_vld_reg, m_vld_next;
    pwps_pkg::res_info_t m_info_reg;
    logic [SW-1:0]       m_sample_reg;

    pwps_pkg::ram_req_t  ram_req;
    logic [SW-1:0]       ram_rdata;

    logic [TW-1:0]       in_now;
    logic [AW-1:0]       in_addr;
    logic [SW-1:0]       in_value;
    pwps_pkg::opcode_t   in_op;
    logic                s_accept;
    logic [LW-1:0]       len_sat;
    logic [CW-1:0]       n_sat;
    logic [TW-1:0]       diff;
    logic                due;
    logic [LW-1:0]       rem_sh;
    logic [LW-1:0]       rem_new;
    logic [AW-1:0]       idx_inc;
    logic                last_item;
    logic                out_load;
    logic                issue_ok;

    assign in_now   = s_axis_tdata[31:0];
    assign in_addr  = s_axis_tdata[40:32];
    assign in_value = s_axis_tdata[56:41];
    assign in_op    = pwps_pkg::opcode_t'(s_axis_tuser);

    assign s_axis_tready = (state_reg == pwps_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign len_sat = (tlen_reg > LW'(pwps_pkg::TABLE_DEPTH)) ?
                     LW'(pwps_pkg::TABLE_DEPTH) : LW'(tlen_reg);
    assign n_sat   = (nsamp_reg > 6'(pwps_pkg::MAX_SAMPLES)) ?
                     CW'(pwps_pkg::MAX_SAMPLES) : CW'(nsamp_reg);
    assign diff    = in_now - deadline_reg;
    assign due     = (period_reg != 16'd0) && (len_sat != '0) && !diff[TW-1];

    assign rem_sh    = {rem_reg[LW-2:0], rdidx_reg[bit_reg]};
    assign rem_new   = (rem_sh >= len_reg) ? (rem_sh - len_reg) : rem_sh;
    assign idx_inc   = ((LW'(idx_reg) + LW'(1)) == len_reg) ? '0 : (idx_reg + AW'(1));
    assign last_item = (n_reg == '0) || ((cnt_reg + CW'(1)) == n_reg);

    assign out_load  = s1_vld_reg && (!m_vld_reg || m_axis_tready);
    assign issue_ok  = !s1_vld_reg || out_load;

    pwps_table_ram u_table (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        rdidx_next    = rdidx_reg;
        seq_next      = seq_reg;
        deadline_next = deadline_reg;
        time_next     = time_reg;
        len_next      = len_reg;
        n_next        = n_reg;
        start_next    = start_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        s1_vld_next   = out_load ? 1'b0 : s1_vld_reg;
        s1_info_next  = s1_info_reg;
        ram_req       = '0;
        ram_req.waddr = in_addr;
        ram_req.wdata = in_value;
        ram_req.raddr = idx_reg;

        case (state_reg)
            pwps_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (in_op)
                        pwps_pkg::OP_WRITE: begin
                            ram_req.we = ((AW + 1)'(in_addr) <
                                          (AW + 1)'(pwps_pkg::TABLE_DEPTH));
                        end
                        pwps_pkg::OP_RESTART: begin
                            seq_next      = '0;
                            rdidx_next    = '0;
                            deadline_next = in_now + ((period_reg == 16'd0) ?
                                            TW'(1) : TW'(period_reg));
                        end
                        pwps_pkg::OP_TICK: begin
                            if (due) begin
                                time_next = in_now;
                                len_next  = len_sat;
                                n_next    = n_sat;
                                cnt_next  = '0;
                                if (LW'(rdidx_reg) < len_sat) begin
                                    start_next = rdidx_reg;
                                    idx_next   = rdidx_reg;
                                    state_next = pwps_pkg::ST_ISSUE;
                                end else begin
                                    rem_next   = '0;
                                    bit_next   = BW'(AW - 1);
                                    state_next = pwps_pkg::ST_MOD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pwps_pkg::ST_MOD: begin
                rem_next = rem_new;
                if (bit_reg == '0) begin
                    start_next = rem_new[AW-1:0];
                    idx_next   = rem_new[AW-1:0];
                    state_next = pwps_pkg::ST_ISSUE;
                end else begin
                    bit_next = bit_reg - BW'(1);
                end
            end
            pwps_pkg::ST_ISSUE: begin
                if (issue_ok) begin
                    ram_req.re         = (n_reg != '0);
                    s1_vld_next        = 1'b1;
                    s1_info_next.seq   = seq_reg;
                    s1_info_next.ptime = time_reg;
                    s1_info_next.start = start_reg;
                    s1_info_next.total = pwps_pkg::TOTAL_W'(n_reg);
                    s1_info_next.slot  = cnt_reg[pwps_pkg::SLOT_W-1:0];
                    s1_info_next.last  = last_item;
                    s1_info_next.zero  = (n_reg == '0);
                    if (last_item) begin
                        rdidx_next    = (n_reg == '0) ? start_reg : idx_inc;
                        seq_next      = seq_reg + TW'(1);
                        deadline_next = deadline_reg + TW'(period_reg);
                        state_next    = pwps_pkg::ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + CW'(1);
                        idx_next = idx_inc;
                    end
                end
            end
            default: begin
                state_next = pwps_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_vld_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pwps_pkg::ST_IDLE;
            period_reg   <= pwps_pkg::RST_PERIOD;
            tlen_reg     <= pwps_pkg::RST_TLEN;
            nsamp_reg    <= pwps_pkg::RST_NSAMP;
            rdidx_reg    <= '0;
            seq_reg      <= '0;
            deadline_reg <= '0;
            s1_vld_reg   <= 1'b0;
            m_vld_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rdidx_reg    <= rdidx_next;
            seq_reg      <= seq_next;
            deadline_reg <= deadline_next;
            s1_vld_reg   <= s1_vld_next;
            m_vld_reg    <= m_vld_next;
            if (cfg_we) begin
                case (pwps_pkg::cfg_idx_t'(cfg_addr))
                    pwps_pkg::CFG_PERIOD: period_reg <= cfg_wdata;
                    pwps_pkg::CFG_TLEN:   tlen_reg   <= cfg_wdata[9:0];
                    pwps_pkg::CFG_NSAMP:  nsamp_reg  <= cfg_wdata[5:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        time_reg    <= time_next;
        len_reg     <= len_next;
        n_reg       <= n_next;
        start_reg   <= start_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        s1_info_reg <= s1_info_next;
        if (out_load) begin
            m_info_reg   <= s1_info_reg;
            m_sample_reg <= s1_info_reg.zero ? '0 : ram_rdata;
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tlast  = m_info_reg.last;
    assign m_axis_tdata  = {4'd0, m_sample_reg, m_info_reg.slot, m_info_reg.total,
                            m_info_reg.start, m_info_reg.ptime, m_info_reg.seq};

`ifndef SYNTHESIS
    a_ram_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_req.we && ram_req.re))
        else $error("table write and read in the same cycle");

    a_rdata_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && !s1_info_reg.zero && !out_load) |=> $stable(ram_rdata))
        else $error("table read data changed while the read stage was stalled");

    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |->
        ((m_info_reg.total == '0) ||
         ((pwps_pkg::TOTAL_W'(m_info_reg.slot) + pwps_pkg::TOTAL_W'(1)) ==
          m_info_reg.total)))
        else $error("last flag on a sample that is not the final slot");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pwps_pkg::ST_ISSUE) |->
        ((cnt_reg < n_reg) || ((n_reg == '0) && (cnt_reg == '0))))
        else $error("sample counter ran past the packet size");
`endif

endmodule

// File: src/pwps_table_ram.sv
// Sample table of the periodic wavetable packet source: one write port and
// one read port with a registered read that holds while no read is requested.
// Depends on pwps_pkg.
module pwps_table_ram (
    input  logic                              aclk,
    input  pwps_pkg::ram_req_t                req,
    output logic [pwps_pkg::SAMPLE_W-1:0]     rd_data
);

    logic [pwps_pkg::SAMPLE_W-1:0] mem_reg [pwps_pkg::TABLE_DEPTH];
    logic [pwps_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data_reg <= mem_reg[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: test/tb_periodic_wavetable_packet_source.sv
// Testbench for periodic_wavetable_packet_source: drives table writes, restarts
// and millisecond ticks over several register settings and checks every packet
// sample against a local prediction. Depends on pwps_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_periodic_wavetable_packet_source;

    localparam logic [1:0] OP_NOOP = 2'd3;
    localparam int N_PHASES = 15;
    localparam int PHASE_ITEMS = 12;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now;
        logic [8:0]  addr;
        logic [15:0] value;
    } src_item_t;

    typedef struct packed {
        logic [31:0] seq_no;
        logic [31:0] due_ms;
        logic [8:0]  rd_idx;
        logic [15:0] period;
        logic [9:0]  tlen;
        logic [5:0]  nsamp;
    } src_state_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ptime;
        logic [8:0]  start;
        logic [5:0]  total;
        logic [4:0]  slot;
        logic [15:0] smp;
        logic        last;
    } pkt_beat_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;  // now_ms, table_addr, table_value
    logic [1:0]   s_axis_tuser = '0;  // opcode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;       // packet_seq, packet_time, start_index,
                                      // sample_total, sample_slot, sample
    logic         m_axis_tlast;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = '0;
    logic [15:0]  cfg_wdata = '0;

    periodic_wavetable_packet_source DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    src_state_t  gen_view;
    src_state_t  dut_view;
    logic [15:0] wave_mem [pwps_pkg::TABLE_DEPTH];
    bit          written [pwps_pkg::TABLE_DEPTH];
    src_item_t   to_send [$];
    pkt_beat_t   beats_due [$];
    src_item_t   on_wire;
    logic [31:0] clk_ms;

    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_beats = 0;
    int  n_packets = 0;
    int  errors = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_left = 0;
    bit  sent_flag = 1'b0;
    bit  idle_on = 1'b1;
    bit  long_hold_req = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned eff_len(input src_state_t st);
        return (st.tlen > pwps_pkg::TABLE_DEPTH) ? pwps_pkg::TABLE_DEPTH : st.tlen;
    endfunction

    function automatic void restart_state(inout src_state_t st, input logic [31:0] now);
        st.seq_no = '0;
        st.rd_idx = '0;
        st.due_ms = now + ((st.period == 0) ? 32'd1 : {16'd0, st.period});
    endfunction

    // Returns 1 when the tick is due; the state then moves on past the packet.
    function automatic bit advance_tick(inout src_state_t st, input logic [31:0] now,
                                        output logic [8:0] start, output logic [5:0] cnt);
        int unsigned len;
        int unsigned n;
        int unsigned s;
        logic [31:0] diff;
        start = '0;
        cnt = '0;
        len = eff_len(st);
        if (st.period == 0 || len == 0) begin
            return 1'b0;
        end
        diff = now - st.due_ms;
        if (diff[31]) begin
            return 1'b0;
        end
        n = (st.nsamp > pwps_pkg::MAX_SAMPLES) ? pwps_pkg::MAX_SAMPLES : st.nsamp;
        s = st.rd_idx % len;
        start = s[8:0];
        cnt = n[5:0];
        st.rd_idx = 9'((s + n) % len);
        st.seq_no = st.seq_no + 1;
        st.due_ms = st.due_ms + {16'd0, st.period};
        return 1'b1;
    endfunction

    function automatic void absorb_item(input src_item_t it);
        logic [31:0] seq0;
        logic [8:0]  start;
        logic [5:0]  cnt;
        pkt_beat_t   b;
        int unsigned len;
        case (it.op)
            pwps_pkg::OP_WRITE: begin
                wave_mem[it.addr] = it.value;
            end
            pwps_pkg::OP_RESTART: begin
                restart_state(dut_view, it.now);
            end
            pwps_pkg::OP_TICK: begin
                seq0 = dut_view.seq_no;
                len = eff_len(dut_view);
                if (advance_tick(dut_view, it.now, start, cnt)) begin
                    b.seq = seq0;
                    b.ptime = it.now;
                    b.start = start;
                    b.total = cnt;
                    if (cnt == 0) begin
                        b.slot = '0;
                        b.smp = '0;
                        b.last = 1'b1;
                        beats_due.push_back(b);
                    end else begin
                        for (int i = 0; i < cnt; i++) begin
                            b.slot = i[4:0];
                            b.smp = wave_mem[(start + i) % len];
                            b.last = (i + 1 == cnt);
                            beats_due.push_back(b);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic src_item_t op_item(input logic [1:0] op, input logic [31:0] now);
        src_item_t it;
        it.op = op;
        it.now = now;
        it.addr = 9'($urandom);
        it.value = 16'($urandom);
        return it;
    endfunction

    function automatic src_item_t wr_item(input int unsigned addr, input logic [15:0] value);
        src_item_t it;
        it = op_item(pwps_pkg::OP_WRITE, $urandom);
        it.addr = addr[8:0];
        it.value = value;
        return it;
    endfunction

    // Ticks that will read entries not yet written get those writes queued first.
    function automatic void queue_item(input src_item_t it);
        src_state_t  probe;
        logic [8:0]  start;
        logic [5:0]  cnt;
        int unsigned idx;
        probe = gen_view;
        if (it.op == pwps_pkg::OP_TICK && advance_tick(probe, it.now, start, cnt)) begin
            for (int i = 0; i < cnt; i++) begin
                idx = (start + i) % eff_len(probe);
                if (!written[idx]) begin
                    written[idx] = 1'b1;
                    to_send.push_back(wr_item(idx, 16'($urandom)));
                    n_queued++;
                end
            end
        end
        if (it.op == pwps_pkg::OP_WRITE) begin
            written[it.addr] = 1'b1;
        end else if (it.op == pwps_pkg::OP_RESTART) begin
            restart_state(gen_view, it.now);
        end else if (it.op == pwps_pkg::OP_TICK) begin
            gen_view = probe;
        end
        to_send.push_back(it);
        n_queued++;
    endfunction

    task automatic write_reg(input pwps_pkg::cfg_idx_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            pwps_pkg::CFG_PERIOD: begin
                gen_view.period = val;
                dut_view.period = val;
            end
            pwps_pkg::CFG_TLEN: begin
                gen_view.tlen = val[9:0];
                dut_view.tlen = val[9:0];
            end
            default: begin
                gen_view.nsamp = val[5:0];
                dut_view.nsamp = val[5:0];
            end
        endcase
    endtask

    task automatic drain_and_pause();
        while (n_accepted != n_queued || beats_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (24) @(posedge aclk);
    endtask

    task automatic rand_phase(input int count, input bit do_restart);
        int unsigned per;
        int unsigned r;
        logic [31:0] stride;
        if (do_restart) begin
            clk_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300)
                                                 : $urandom;
            queue_item(op_item(pwps_pkg::OP_RESTART, clk_ms));
        end
        for (int k = 0; k < count; k++) begin
            per = (gen_view.period == 0) ? 1 : gen_view.period;
            r = $urandom_range(0, 99);
            if (r < 60) begin
                case ($urandom_range(0, 9))
                    0: stride = '0;
                    1, 2, 3: stride = $urandom_range(0, per);
                    4: stride = $urandom_range(per, 4 * per + 3);
                    default: stride = per;
                endcase
                clk_ms = clk_ms + stride;
                queue_item(op_item(pwps_pkg::OP_TICK, clk_ms));
            end else if (r < 75) begin
                queue_item(wr_item($urandom_range(0, pwps_pkg::TABLE_DEPTH - 1),
                                   16'($urandom)));
            end else if (r < 82) begin
                queue_item(op_item(pwps_pkg::OP_RESTART, clk_ms));
            end else if (r < 88) begin
                queue_item(op_item(OP_NOOP, $urandom));
            end else if (r < 94) begin
                queue_item(op_item(pwps_pkg::OP_TICK, $urandom));
            end else begin
                queue_item(op_item(pwps_pkg::OP_TICK, clk_ms - $urandom_range(0, per)));
            end
        end
    endtask

    // Result checking and input bookkeeping at the rising edge, driving at the
    // falling edge.
    always @(posedge aclk) begin
        pkt_beat_t got;
        pkt_beat_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.seq = m_axis_tdata[31:0];
            got.ptime = m_axis_tdata[63:32];
            got.start = m_axis_tdata[72:64];
            got.total = m_axis_tdata[78:73];
            got.slot = m_axis_tdata[83:79];
            got.smp = m_axis_tdata[99:84];
            got.last = m_axis_tlast;
            n_beats++;
            if (got.last) begin
                n_packets++;
            end
            if (beats_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result seq=%0d time=%h start=%0d total=%0d",
                         $time, got.seq, got.ptime, got.start, got.total,
                         " slot=%0d sample=%h last=%b", got.slot, got.smp, got.last);
            end else begin
                want = beats_due.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected seq=%0d time=%h start=%0d total=%0d",
                             $time, want.seq, want.ptime, want.start, want.total,
                             " slot=%0d sample=%h last=%b", want.slot, want.smp,
                             want.last);
                    $display("%0t:          actual   seq=%0d time=%h start=%0d total=%0d",
                             $time, got.seq, got.ptime, got.start, got.total,
                             " slot=%0d sample=%h last=%b", got.slot, got.smp,
                             got.last);
                end
            end
        end
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            absorb_item(on_wire);
            n_accepted++;
            sent_flag = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || sent_flag) begin
            sent_flag = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(0, 7);
                s_axis_tvalid <= 1'b0;
            end else if (to_send.size() > 0) begin
                on_wire = to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'd0, on_wire.value, on_wire.addr, on_wire.now};
                s_axis_tuser <= on_wire.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        int unsigned period_v;
        int unsigned tlen_v;
        int unsigned nsamp_v;
        logic [15:0] junk;
        bit          do_restart;
        gen_view = '{seq_no: '0, due_ms: '0, rd_idx: '0, period: pwps_pkg::RST_PERIOD,
                     tlen: pwps_pkg::RST_TLEN, nsamp: pwps_pkg::RST_NSAMP};
        dut_view = gen_view;
        clk_ms = '0;
        foreach (written[i]) begin
            written[i] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Short circular table with more samples than entries, period left at reset.
        write_reg(pwps_pkg::CFG_NSAMP, 16'd4);
        write_reg(pwps_pkg::CFG_TLEN, 16'd3);
        queue_item(wr_item(0, 16'h7FFF));
        queue_item(wr_item(1, 16'h8000));
        queue_item(wr_item(2, 16'h0000));
        queue_item(wr_item(511, 16'hFFFF));
        queue_item(op_item(pwps_pkg::OP_TICK, 32'h0000_0000));
        queue_item(op_item(pwps_pkg::OP_TICK, 32'h0000_0000));
        queue_item(op_item(pwps_pkg::OP_TICK, 32'h0000_0001));
        queue_item(op_item(pwps_pkg::OP_TICK, 32'hFFFF_FFFF));
        queue_item(op_item(pwps_pkg::OP_TICK, 32'h8000_0001));
        queue_item(op_item(pwps_pkg::OP_TICK, 32'h8000_0003));
        queue_item(op_item(OP_NOOP, 32'h0000_0000));
        queue_item(op_item(pwps_pkg::OP_RESTART, 32'hFFFF_FFFF));
        queue_item(op_item(pwps_pkg::OP_TICK, 32'h0000_0000));
        for (int k = 0; k < 5; k++) begin
            queue_item(op_item(pwps_pkg::OP_TICK, 32'h0000_0005));
        end
        queue_item(wr_item(1, 16'h1234));
        queue_item(op_item(pwps_pkg::OP_TICK, 32'h0000_0006));
        clk_ms = 32'd6;
        drain_and_pause();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            do_restart = 1'b1;
            case (ph)
                0: begin period_v = 1;     tlen_v = 360;  nsamp_v = 32; end
                1: begin period_v = 3;     tlen_v = 5;    nsamp_v = 7;  end
                2: begin period_v = 0;     tlen_v = 8;    nsamp_v = 4;  end
                3: begin period_v = 2;     tlen_v = 0;    nsamp_v = 4;  end
                4: begin period_v = 1;     tlen_v = 1023; nsamp_v = 63; end
                5: begin period_v = 65535; tlen_v = 17;   nsamp_v = 0;  end
                6: begin period_v = 1;     tlen_v = 512;  nsamp_v = 32; end
                7: begin
                    period_v = 1;
                    tlen_v = 10;
                    nsamp_v = 6;
                    do_restart = 1'b0;
                end
                8: begin period_v = 5;     tlen_v = 3;    nsamp_v = 33; end
                default: begin
                    case ($urandom_range(0, 5))
                        0: period_v = 0;
                        1: period_v = 1;
                        2: period_v = $urandom_range(2, 9);
                        3: period_v = $urandom_range(10, 300);
                        4: period_v = 65535;
                        default: period_v = $urandom_range(1, 4);
                    endcase
                    case ($urandom_range(0, 4))
                        0: tlen_v = $urandom_range(0, 1023);
                        1: tlen_v = 1;
                        default: tlen_v = $urandom_range(2, 40);
                    endcase
                    nsamp_v = $urandom_range(0, 63);
                    do_restart = ($urandom_range(0, 4) != 0);
                end
            endcase
            junk = 16'($urandom);
            write_reg(pwps_pkg::CFG_PERIOD, period_v[15:0]);
            write_reg(pwps_pkg::CFG_TLEN, $urandom_range(0, 1) ? {junk[15:10], tlen_v[9:0]}
                                                               : {6'd0, tlen_v[9:0]});
            write_reg(pwps_pkg::CFG_NSAMP, $urandom_range(0, 1) ? {junk[9:0], nsamp_v[5:0]}
                                                                : {10'd0, nsamp_v[5:0]});
            if (ph == 6) begin
                long_hold_req = 1'b1;
            end
            if (ph == N_PHASES - 1) begin
                idle_on = 1'b0;
            end
            rand_phase(PHASE_ITEMS, do_restart);
            drain_and_pause();
        end

        $display("Run covered %0d input transfers and %0d result transfers (%0d packets)",
                 n_accepted, n_beats, n_packets);
        $display("over %0d register settings, with %0d mismatches.", N_PHASES + 1, errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #(8_000_000);
        $display("Timeout with %0d results still expected.", beats_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
